### sv/jst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jst_pkg
// Shared widths, codes and the slot entry type for the job slot table.
// ----------------------------------------------------------------------------
package jst_pkg;

    localparam int SLOT_COUNT = 16;
    localparam int IDX_W      = $clog2(SLOT_COUNT);
    localparam int PID_W      = 22;
    localparam int JID_W      = 5;
    localparam int RS_W       = 2;
    localparam int CMD_W      = 3;
    localparam int STATUS_W   = 2;

    // command codes
    localparam logic [CMD_W-1:0] CMD_ADD      = 3'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_FIND_PID = 3'd2;
    localparam logic [CMD_W-1:0] CMD_FIND_JID = 3'd3;
    localparam logic [CMD_W-1:0] CMD_FIND_FG  = 3'd4;

    // status codes
    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_INVALID  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_NOTFOUND = 2'd3;

    // run state codes
    localparam logic [RS_W-1:0] RS_FOREGROUND = 2'd1;

    typedef struct packed {
        logic [PID_W-1:0] pid;
        logic [JID_W-1:0] jid;
        logic [RS_W-1:0]  run_state;
    } slot_entry_t;

endpackage

### sv/jst_match_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jst_match_unit
// Shared compare unit: tests one slot entry against the key of the command.
// ----------------------------------------------------------------------------
module jst_match_unit
(
    input  logic [jst_pkg::CMD_W-1:0] cmd,
    input  logic [jst_pkg::PID_W-1:0] proc_id,
    input  logic [jst_pkg::JID_W-1:0] job_key,
    input  jst_pkg::slot_entry_t      entry,
    output logic                      hit
);

    // select the field and key to compare by command
    always_comb
    begin
        unique case (cmd)
            jst_pkg::CMD_ADD:
                hit = (entry.pid == '0);
            jst_pkg::CMD_DELETE,
            jst_pkg::CMD_FIND_PID:
                hit = (entry.pid == proc_id);
            jst_pkg::CMD_FIND_JID:
                hit = (entry.jid == job_key);
            jst_pkg::CMD_FIND_FG:
                hit = (entry.run_state == jst_pkg::RS_FOREGROUND);
            default:
                hit = 1'b0;
        endcase
    end

endmodule

### sv/job_slot_table_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// job_slot_table_unit
// Table of job slots (pid, job id, run state) driven by one command stream.
// ----------------------------------------------------------------------------
// Usage:
//   Commands enter on the s_ channel (add, delete, find by pid, find by job
//   id, find foreground); each gives exactly one result on the m_ channel.
//   After a command transaction the sequencer walks all SLOT_COUNT slots, one
//   slot a cycle, through a single shared compare unit, then in its finish
//   state writes the table and loads the result register. A zero key or
//   unused command skips the walk and goes straight to the finish state.
//   s_tready is high only while the sequencer is idle, so a new command is
//   accepted only after the previous one has left the finish state.
//   The result sits in an output register, so a new command is accepted while
//   an earlier result still waits; if the receiver stalls, the next command
//   holds in its final cycle until the result register frees up.
//   Reset clears all slots (pid 0, free), sets the next job id to 1 and
//   drops m_tvalid.
// ----------------------------------------------------------------------------
module job_slot_table_unit
(
    input  logic        clk,
    input  logic        rst_n,
    // cmd[2:0], proc_id[24:3], job_key[29:25], run_state[31:30]
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,
    // status[1:0], found_pid[23:2], found_jid[28:24], found_state[30:29],
    // zero pad[31]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata
);

    localparam logic [1:0] SEQ_IDLE   = 2'd0;
    localparam logic [1:0] SEQ_SCAN   = 2'd1;
    localparam logic [1:0] SEQ_FINISH = 2'd2;

    localparam logic [jst_pkg::IDX_W-1:0] LAST_IDX =
        jst_pkg::IDX_W'(jst_pkg::SLOT_COUNT - 1);
    localparam int JID_MAX = (1 << jst_pkg::JID_W) - 1;

    // slot table
    logic [jst_pkg::PID_W-1:0] slot_pid_reg   [jst_pkg::SLOT_COUNT];
    logic [jst_pkg::JID_W-1:0] slot_jid_reg   [jst_pkg::SLOT_COUNT];
    logic [jst_pkg::RS_W-1:0]  slot_state_reg [jst_pkg::SLOT_COUNT];
    logic [jst_pkg::JID_W-1:0] next_jid_reg;

    // sequencer and command registers
    logic [1:0]                   seq_reg;
    logic [jst_pkg::IDX_W-1:0]    scan_idx_reg;
    logic [jst_pkg::CMD_W-1:0]    cmd_reg;
    logic [jst_pkg::PID_W-1:0]    pid_reg;
    logic [jst_pkg::JID_W-1:0]    key_reg;
    logic [jst_pkg::RS_W-1:0]     rs_reg;
    logic                         invalid_reg;
    logic                         found_reg;
    logic [jst_pkg::IDX_W-1:0]    hit_idx_reg;
    jst_pkg::slot_entry_t         hit_entry_reg;
    logic [jst_pkg::JID_W-1:0]    max_jid_reg;

    // output register
    logic                          out_valid_reg;
    logic [jst_pkg::STATUS_W-1:0]  out_status_reg;
    jst_pkg::slot_entry_t          out_entry_reg;

    // input field split
    logic [jst_pkg::CMD_W-1:0] in_cmd;
    logic [jst_pkg::PID_W-1:0] in_pid;
    logic [jst_pkg::JID_W-1:0] in_key;
    logic [jst_pkg::RS_W-1:0]  in_rs;
    logic                      in_invalid;
    logic                      s_fire;

    assign in_cmd = s_tdata[2:0];
    assign in_pid = s_tdata[24:3];
    assign in_key = s_tdata[29:25];
    assign in_rs  = s_tdata[31:30];

    // zero keys and unused commands are rejected without a walk
    always_comb
    begin
        unique case (in_cmd)
            jst_pkg::CMD_ADD,
            jst_pkg::CMD_DELETE,
            jst_pkg::CMD_FIND_PID:
                in_invalid = (in_pid == '0);
            jst_pkg::CMD_FIND_JID:
                in_invalid = (in_key == '0);
            jst_pkg::CMD_FIND_FG:
                in_invalid = 1'b0;
            default:
                in_invalid = 1'b1;
        endcase
    end

    assign s_tready = (seq_reg == SEQ_IDLE);
    assign s_fire   = s_tvalid && s_tready;

    // slot under the scan pointer and the shared compare
    jst_pkg::slot_entry_t scan_entry;
    logic                 scan_hit;
    logic                 first_hit;

    assign scan_entry.pid       = slot_pid_reg[scan_idx_reg];
    assign scan_entry.jid       = slot_jid_reg[scan_idx_reg];
    assign scan_entry.run_state = slot_state_reg[scan_idx_reg];

    jst_match_unit u_match
    (
        .cmd     (cmd_reg),
        .proc_id (pid_reg),
        .job_key (key_reg),
        .entry   (scan_entry),
        .hit     (scan_hit)
    );

    assign first_hit = scan_hit && !found_reg;

    // result and table update in the finish cycle
    logic                          finish_fire;
    logic [jst_pkg::STATUS_W-1:0]  status_next;
    jst_pkg::slot_entry_t          entry_next;
    logic [6:0]                    add_sum;
    logic [jst_pkg::JID_W:0]       del_sum;
    logic [jst_pkg::JID_W-1:0]     add_jid_next;
    logic [jst_pkg::JID_W-1:0]     del_jid_next;

    assign finish_fire = (seq_reg == SEQ_FINISH) && (!out_valid_reg || m_tready);

    assign add_sum = {2'b00, next_jid_reg} + 7'd1;
    assign add_jid_next = ((add_sum > 7'(jst_pkg::SLOT_COUNT)) || (add_sum > 7'(JID_MAX)))
                          ? jst_pkg::JID_W'(1) : add_sum[jst_pkg::JID_W-1:0];
    assign del_sum = {1'b0, max_jid_reg} + (jst_pkg::JID_W+1)'(1);
    assign del_jid_next = (del_sum > (jst_pkg::JID_W+1)'(JID_MAX))
                          ? jst_pkg::JID_W'(1) : del_sum[jst_pkg::JID_W-1:0];

    always_comb
    begin
        entry_next = '0;
        priority if (invalid_reg)
        begin
            status_next = jst_pkg::STATUS_INVALID;
        end
        else if (found_reg)
        begin
            status_next = jst_pkg::STATUS_OK;
            if (cmd_reg == jst_pkg::CMD_ADD)
            begin
                entry_next.pid       = pid_reg;
                entry_next.jid       = next_jid_reg;
                entry_next.run_state = rs_reg;
            end
            else
            begin
                entry_next = hit_entry_reg;
            end
        end
        else if (cmd_reg == jst_pkg::CMD_ADD)
        begin
            status_next = jst_pkg::STATUS_FULL;
        end
        else
        begin
            status_next = jst_pkg::STATUS_NOTFOUND;
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg      <= SEQ_IDLE;
            scan_idx_reg <= '0;
            found_reg    <= 1'b0;
            invalid_reg  <= 1'b0;
        end
        else
        begin
            unique case (seq_reg)
                SEQ_IDLE:
                begin
                    if (s_fire)
                    begin
                        invalid_reg  <= in_invalid;
                        found_reg    <= 1'b0;
                        scan_idx_reg <= '0;
                        seq_reg      <= in_invalid ? SEQ_FINISH : SEQ_SCAN;
                    end
                end
                SEQ_SCAN:
                begin
                    if (first_hit)
                    begin
                        found_reg <= 1'b1;
                    end
                    if (scan_idx_reg == LAST_IDX)
                    begin
                        seq_reg <= SEQ_FINISH;
                    end
                    else
                    begin
                        scan_idx_reg <= scan_idx_reg + jst_pkg::IDX_W'(1);
                    end
                end
                SEQ_FINISH:
                begin
                    if (finish_fire)
                    begin
                        seq_reg <= SEQ_IDLE;
                    end
                end
                default:
                begin
                    seq_reg <= SEQ_IDLE;
                end
            endcase
        end
    end

    // command capture and scan datapath
    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            cmd_reg     <= in_cmd;
            pid_reg     <= in_pid;
            key_reg     <= in_key;
            rs_reg      <= in_rs;
            max_jid_reg <= '0;
        end
        else if (seq_reg == SEQ_SCAN)
        begin
            if (first_hit)
            begin
                hit_idx_reg   <= scan_idx_reg;
                hit_entry_reg <= scan_entry;
            end
            // largest job id, leaving out the slot a delete will clear
            else if (scan_entry.jid > max_jid_reg)
            begin
                max_jid_reg <= scan_entry.jid;
            end
        end
    end

    // slot table and next job id
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < jst_pkg::SLOT_COUNT; i++)
            begin
                slot_pid_reg[i]   <= '0;
                slot_jid_reg[i]   <= '0;
                slot_state_reg[i] <= '0;
            end
            next_jid_reg <= jst_pkg::JID_W'(1);
        end
        else if (finish_fire && !invalid_reg && found_reg)
        begin
            if (cmd_reg == jst_pkg::CMD_ADD)
            begin
                slot_pid_reg[hit_idx_reg]   <= pid_reg;
                slot_jid_reg[hit_idx_reg]   <= next_jid_reg;
                slot_state_reg[hit_idx_reg] <= rs_reg;
                next_jid_reg                <= add_jid_next;
            end
            else if (cmd_reg == jst_pkg::CMD_DELETE)
            begin
                slot_pid_reg[hit_idx_reg]   <= '0;
                slot_jid_reg[hit_idx_reg]   <= '0;
                slot_state_reg[hit_idx_reg] <= '0;
                next_jid_reg                <= del_jid_next;
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (finish_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish_fire)
        begin
            out_status_reg <= status_next;
            out_entry_reg  <= entry_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_entry_reg.run_state, out_entry_reg.jid,
                       out_entry_reg.pid, out_status_reg};

endmodule
